/* rtl/dtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_pkg
// Shared constants and types of the dirty tile detector.
// ----------------------------------------------------------------------------
package dtd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int TILE_SIZE  = 64;

   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int TILE_W  = $clog2(TILE_SIZE);
   localparam int TX_W    = COL_W - TILE_W;
   localparam int TY_W    = ROW_W - TILE_W;
   localparam int TILES_X = (MAX_WIDTH + TILE_SIZE - 1) / TILE_SIZE;
   localparam int TILES   = TILES_X * ((MAX_HEIGHT + TILE_SIZE - 1) / TILE_SIZE);
   localparam int TIDX_W  = TX_W + TY_W;
   localparam int FADDR_W = 1 + ROW_W + COL_W;
   localparam int FDEPTH  = 2 * MAX_WIDTH * MAX_HEIGHT;

   localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DIFF   = 2'd2;

   localparam logic REQ_PIXEL  = 1'b0;
   localparam logic REQ_COMMIT = 1'b1;

   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_MARKER = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [9:0]  x;
      logic [9:0]  y;
      logic [10:0] w;
      logic [10:0] h;
      logic        dirty;
   } res_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic [1:0] byte_sel;
   } hash_ctl_type;

endpackage

/* rtl/dtd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_if
// Request, response and register write channels of the dirty tile detector.
// ----------------------------------------------------------------------------
interface dtd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] pixel;
   modport source (output valid, req_type, pixel, input ready);
   modport sink   (input valid, req_type, pixel, output ready);
endinterface

interface dtd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  rect_x;
   logic [9:0]  rect_y;
   logic [10:0] rect_w;
   logic [10:0] rect_h;
   logic        any_dirty;
   logic        last;
   modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, any_dirty, last,
                   input ready);
   modport sink   (input valid, kind, rect_x, rect_y, rect_w, rect_h, any_dirty, last,
                   output ready);
endinterface

interface dtd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [10:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/dtd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_ram
// Generic single write, single read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dtd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* rtl/dtd_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtd_hasher
// FNV-1a 64 accumulator, folding one pixel byte per step.
// ----------------------------------------------------------------------------
module dtd_hasher
   import dtd_pkg::*;
(
   input  logic         clock,
   input  hash_ctl_type ctl,
   input  logic [63:0]  init_hash,
   input  logic [31:0]  pixel,
   output logic [63:0]  hash
);

   logic [63:0] hash_ff, hash_in, mixed;
   logic [7:0]  byte_val;

   always_comb begin
      byte_val = pixel[8*ctl.byte_sel +: 8];
      mixed    = hash_ff ^ {56'd0, byte_val};
      // The prime is 2^40 + 0x1B3, so the product is a short shift-add.
      hash_in  = hash_ff;
      if (ctl.load) begin
         hash_in = init_hash;
      end else if (ctl.step) begin
         hash_in = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
                 + (mixed << 4) + (mixed << 1) + mixed;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
   end

   assign hash = hash_ff;

endmodule

/* rtl/dirty_tile_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_tile_detector
// Per-tile FNV-1a 64 hashing (non-std basis) and previous-frame compare
// of raster pixels, reporting dirty rectangles and an end-of-frame marker.
// ----------------------------------------------------------------------------
// The req channel carries one word per pixel in raster order, or a commit
// word that swaps the ping-pong frame halves. The rsp channel returns up to
// two words per pixel: a dirty rectangle when a tile completes and differs,
// a full-frame rectangle at frame end with diff mode off, and the frame
// marker on the last pixel. The last flag marks the final word of a pixel.
// The csr channel writes width, height and diff mode and is always ready.
// A pixel passes through the frame store read, compare and write-back,
// the four FNV byte steps through the shared hasher, and the tile
// decision; results then leave one per cycle while the receiver is ready.
// The frame store sits in one RAM and the tile hashes in another. After
// reset the frame store is cleared one word per cycle, all 2097152 words,
// with req held not ready. When the receiver stalls, results wait in the
// output register and the block holds before loading the next one.
// ----------------------------------------------------------------------------
module dirty_tile_detector
   import dtd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   dtd_req_if.sink   req,
   dtd_rsp_if.source rsp,
   dtd_csr_if.sink   csr
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_CMP   = 3'd2;
   localparam logic [2:0] ST_HASH  = 3'd3;
   localparam logic [2:0] ST_TILE  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [10:0] width_ff, width_in, height_ff, height_in;
   logic        diff_ff, diff_in;
   logic        sel_ff, sel_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic        dirty_ff, dirty_in;
   logic [FADDR_W-1:0] clr_ff, clr_in;
   logic [1:0]  byte_ff, byte_in;
   logic [31:0] px_ff, px_in;
   logic [63:0] run_ff [TILES_X];
   logic [63:0] run_in [TILES_X];
   logic        diffbit_ff [TILES_X];
   logic        diffbit_in [TILES_X];
   logic [TILES-1:0] hvalid_ff, hvalid_in;
   logic        hv_ff, hv_in;
   res_type     res_ff [2];
   res_type     res_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        idx_ff, idx_in;
   logic        ov_ff, ov_in;
   res_type     out_ff, out_in;
   logic        olast_ff, olast_in;

   logic [10:0] w_eff, h_eff;
   logic [TX_W-1:0]   tx;
   logic [TIDX_W-1:0] tidx;
   logic        end_col, end_row, tile_done, accept, pix_accept, commit_accept;
   logic        fs_we, fs_re, hs_we, hs_re;
   logic [FADDR_W-1:0] fs_waddr;
   logic [31:0] fs_wdata, fs_q;
   logic [63:0] hs_q, stored, hash;
   hash_ctl_type hctl;

   always_comb begin
      w_eff = (width_ff == 11'd0) ? 11'd1 :
              (width_ff > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_ff;
      h_eff = (height_ff == 11'd0) ? 11'd1 :
              (height_ff > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_ff;
      tx      = col_ff[COL_W-1:TILE_W];
      tidx    = {row_ff[ROW_W-1:TILE_W], tx};
      end_col = (11'(col_ff) + 11'd1) >= w_eff;
      end_row = (11'(row_ff) + 11'd1) >= h_eff;
      tile_done = (&col_ff[TILE_W-1:0] || end_col) && (&row_ff[TILE_W-1:0] || end_row);
      stored  = hv_ff ? hs_q : 64'd0;
   end

   assign req.ready     = (state_ff == ST_IDLE);
   assign csr.ready     = 1'b1;
   assign accept        = req.valid && req.ready;
   assign pix_accept    = accept && (req.req_type == REQ_PIXEL);
   assign commit_accept = accept && (req.req_type == REQ_COMMIT);

   assign fs_re = pix_accept;
   assign hs_re = pix_accept;

   always_comb begin
      fs_we    = 1'b0;
      fs_waddr = {!sel_ff, row_ff, col_ff};
      fs_wdata = px_ff;
      if (state_ff == ST_CLEAR) begin
         fs_we    = 1'b1;
         fs_waddr = clr_ff;
         fs_wdata = 32'd0;
      end else if (state_ff == ST_CMP) begin
         fs_we = 1'b1;
      end
   end

   assign hs_we = (state_ff == ST_TILE) && tile_done && diff_ff && (stored != hash);

   dtd_ram #(.WIDTH(32), .DEPTH(FDEPTH)) u_frame_store (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_en   (fs_re),
      .rd_addr ({sel_ff, row_ff, col_ff}),
      .rd_data (fs_q)
   );

   dtd_ram #(.WIDTH(64), .DEPTH(TILES)) u_tile_hash (
      .clock   (clock),
      .wr_en   (hs_we),
      .wr_addr (tidx),
      .wr_data (hash),
      .rd_en   (hs_re),
      .rd_addr (tidx),
      .rd_data (hs_q)
   );

   always_comb begin
      hctl.load     = (state_ff == ST_CMP);
      hctl.step     = (state_ff == ST_HASH);
      hctl.byte_sel = byte_ff;
   end

   dtd_hasher u_hasher (
      .clock     (clock),
      .ctl       (hctl),
      .init_hash (run_ff[tx]),
      .pixel     (px_ff),
      .hash      (hash)
   );

   always_comb begin
      state_in  = state_ff;
      width_in  = width_ff;
      height_in = height_ff;
      diff_in   = diff_ff;
      sel_in    = sel_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      dirty_in  = dirty_ff;
      clr_in    = clr_ff;
      byte_in   = byte_ff;
      px_in     = px_ff;
      run_in    = run_ff;
      diffbit_in = diffbit_ff;
      hvalid_in = hvalid_ff;
      hv_in     = hv_ff;
      res_in    = res_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      ov_in     = ov_ff;
      out_in    = out_ff;
      olast_in  = olast_ff;

      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_WIDTH:  width_in  = csr.data;
            CSR_HEIGHT: height_in = csr.data;
            CSR_DIFF:   diff_in   = csr.data[0];
            default:    ;
         endcase
      end

      if (rsp.valid && rsp.ready) begin
         ov_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (commit_accept) begin
               sel_in = !sel_ff;
            end else if (pix_accept) begin
               px_in    = req.pixel;
               hv_in    = hvalid_ff[tidx];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (fs_q != px_ff) begin
               diffbit_in[tx] = 1'b1;
            end
            byte_in  = 2'd0;
            state_in = ST_HASH;
         end
         ST_HASH: begin
            byte_in = byte_ff + 2'd1;
            if (byte_ff == 2'd3) begin
               state_in = ST_TILE;
            end
         end
         ST_TILE: begin
            cnt_in = 2'd0;
            run_in[tx] = hash;
            if (tile_done) begin
               if (diff_ff && stored != hash) begin
                  hvalid_in[tidx] = 1'b1;
                  if (diffbit_ff[tx]) begin
                     res_in[0].kind  = KIND_RECT;
                     res_in[0].x     = 10'({tx, {TILE_W{1'b0}}});
                     res_in[0].y     = 10'({row_ff[ROW_W-1:TILE_W], {TILE_W{1'b0}}});
                     res_in[0].w     = 11'({1'b0, col_ff[TILE_W-1:0]} + 1'b1);
                     res_in[0].h     = 11'({1'b0, row_ff[TILE_W-1:0]} + 1'b1);
                     res_in[0].dirty = 1'b0;
                     cnt_in   = 2'd1;
                     dirty_in = 1'b1;
                  end
               end
               run_in[tx]     = FNV_BASIS;
               diffbit_in[tx] = 1'b0;
            end
            if (end_col) begin
               col_in = '0;
               if (end_row) begin
                  row_in = '0;
                  if (!diff_ff) begin
                     hvalid_in = '0;
                     res_in[0] = '{KIND_RECT, 10'd0, 10'd0, w_eff, h_eff, 1'b0};
                     res_in[1] = '{KIND_MARKER, 10'd0, 10'd0, 11'd0, 11'd0, 1'b1};
                     cnt_in    = 2'd2;
                  end else if (cnt_in == 2'd1) begin
                     res_in[1] = '{KIND_MARKER, 10'd0, 10'd0, 11'd0, 11'd0, 1'b1};
                     cnt_in    = 2'd2;
                  end else begin
                     res_in[0] = '{KIND_MARKER, 10'd0, 10'd0, 11'd0, 11'd0, dirty_ff};
                     cnt_in    = 2'd1;
                  end
                  dirty_in = 1'b0;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
            idx_in   = 1'b0;
            state_in = (cnt_in == 2'd0) ? ST_IDLE : ST_EMIT;
         end
         ST_EMIT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in    = 1'b1;
               out_in   = res_ff[idx_ff];
               olast_in = ({1'b0, idx_ff} + 2'd1) == cnt_ff;
               idx_in   = 1'b1;
               if (olast_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         width_ff  <= 11'd1024;
         height_ff <= 11'd1024;
         diff_ff   <= 1'b0;
         sel_ff    <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         dirty_ff  <= 1'b0;
         clr_ff    <= '0;
         hvalid_ff <= '0;
         ov_ff     <= 1'b0;
         for (int i = 0; i < TILES_X; i++) begin
            run_ff[i]     <= FNV_BASIS;
            diffbit_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         diff_ff   <= diff_in;
         sel_ff    <= sel_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         dirty_ff  <= dirty_in;
         clr_ff    <= clr_in;
         hvalid_ff <= hvalid_in;
         ov_ff     <= ov_in;
         run_ff     <= run_in;
         diffbit_ff <= diffbit_in;
      end
      byte_ff  <= byte_in;
      px_ff    <= px_in;
      hv_ff    <= hv_in;
      res_ff   <= res_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      out_ff   <= out_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid     = ov_ff;
   assign rsp.kind      = out_ff.kind;
   assign rsp.rect_x    = out_ff.x;
   assign rsp.rect_y    = out_ff.y;
   assign rsp.rect_w    = out_ff.w;
   assign rsp.rect_h    = out_ff.h;
   assign rsp.any_dirty = out_ff.dirty;
   assign rsp.last      = olast_ff;

   a_no_req_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req.ready)
      else $error("req ready during frame store clear");

   a_marker_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.kind == KIND_MARKER) |-> rsp.last)
      else $error("frame marker not flagged last");

   a_cmp_follows_pixel: assert property (@(posedge clock) disable iff (reset)
      pix_accept |=> (state_ff == ST_CMP) && fs_we)
      else $error("accepted pixel not written back");

endmodule

/* dv/dirty_tile_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_tile_detector_tb
// Drives pixel and commit words into the dirty tile detector over several
// frame sizes and diff modes. A model of the tile hashes and the frame store
// predicts every rectangle and frame marker, and each result word is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module dirty_tile_detector_tb
   import dtd_pkg::*;
;

   localparam int HALF = MAX_WIDTH * MAX_HEIGHT;
   localparam logic [63:0] FNV_MULT = 64'd1099511628211;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;
   bit   idle_on = 1'b1;

   dtd_req_if req ();
   dtd_rsp_if rsp ();
   dtd_csr_if csr ();

   dirty_tile_detector i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                              .csr(csr));

   always #10 clock = ~clock;

   typedef struct packed {
      res_type r;
      logic    last;
   } rsp_word_type;

   // Model state.
   logic [31:0] frame_mem [int];
   logic        prev_half;
   logic [63:0] tile_hash_mem [TILES];
   logic [63:0] run_hash [TILES_X];
   logic        tile_diff [TILES_X];
   int          col, row;
   logic        frame_dirty;
   logic [10:0] cfg_width, cfg_height;
   logic        cfg_diff;
   rsp_word_type pending_rsp [$];

   function automatic int clamp_size(logic [10:0] v, int mx);
      if (v == 0) return 1;
      return (v > mx) ? mx : int'(v);
   endfunction

   function automatic rsp_word_type make_word(logic kind, int x, int y, int w, int h,
                                              logic d);
      rsp_word_type o;
      o.r.kind = kind; o.r.x = 10'(x); o.r.y = 10'(y); o.r.w = 11'(w); o.r.h = 11'(h);
      o.r.dirty = d; o.last = 1'b0;
      return o;
   endfunction

   task automatic predict_dirty(logic typ, logic [31:0] px);
      int w, h, tx, ty, addr, n, i;
      logic [63:0] hs;
      logic [31:0] old;
      bit ec, er;
      if (typ == REQ_COMMIT) begin
         prev_half ^= 1'b1;
         return;
      end
      n = 0;
      w = clamp_size(cfg_width, MAX_WIDTH);
      h = clamp_size(cfg_height, MAX_HEIGHT);
      tx = col / TILE_SIZE;
      ty = row / TILE_SIZE;
      addr = row * MAX_WIDTH + col;
      old = frame_mem.exists(prev_half * HALF + addr) ? frame_mem[prev_half * HALF + addr] : 0;
      if (old != px) tile_diff[tx] = 1'b1;
      frame_mem[(!prev_half) * HALF + addr] = px;
      hs = run_hash[tx];
      for (i = 0; i < 4; i++) begin
         hs = (hs ^ px[8*i +: 8]) * FNV_MULT;
      end
      run_hash[tx] = hs;
      ec = (col + 1 >= w);
      er = (row + 1 >= h);
      if ((col % TILE_SIZE == TILE_SIZE - 1 || ec) && (row % TILE_SIZE == TILE_SIZE - 1 || er))
      begin
         if (cfg_diff && tile_hash_mem[ty * TILES_X + tx] != hs) begin
            if (tile_diff[tx]) begin
               pending_rsp.push_back(make_word(KIND_RECT, tx * TILE_SIZE, ty * TILE_SIZE,
                  col - tx * TILE_SIZE + 1, row - ty * TILE_SIZE + 1, 1'b0));
               n++;
               frame_dirty = 1'b1;
            end
            tile_hash_mem[ty * TILES_X + tx] = hs;
         end
         run_hash[tx] = FNV_BASIS;
         tile_diff[tx] = 1'b0;
      end
      if (ec) begin
         col = 0;
         if (er) begin
            row = 0;
            if (!cfg_diff) begin
               foreach (tile_hash_mem[k]) tile_hash_mem[k] = '0;
               pending_rsp.push_back(make_word(KIND_RECT, 0, 0, w, h, 1'b0));
               n++;
               frame_dirty = 1'b1;
            end
            pending_rsp.push_back(make_word(KIND_MARKER, 0, 0, 0, 0, frame_dirty));
            n++;
            frame_dirty = 1'b0;
         end else begin
            row = row + 1;
         end
      end else begin
         col = col + 1;
      end
      if (n > 0) pending_rsp[$].last = 1'b1;
   endtask

   task automatic random_gap();
      if (idle_on && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 14)) @(negedge clock);
   endtask

   task automatic send_word(logic typ, logic [31:0] px);
      @(negedge clock);
      random_gap();
      req.valid <= 1'b1;
      req.req_type <= typ;
      req.pixel <= px;
      do @(posedge clock); while (!req.ready);
      predict_dirty(typ, px);
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [10:0] val);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_WIDTH) cfg_width = val;
      else if (idx == CSR_HEIGHT) cfg_height = val;
      else if (idx == CSR_DIFF) cfg_diff = val[0];
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic set_frame(logic [10:0] w, logic [10:0] h, logic d);
      wait_drained();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_DIFF, {10'd0, d});
   endtask

   function automatic int frame_pixels();
      return clamp_size(cfg_width, MAX_WIDTH) * clamp_size(cfg_height, MAX_HEIGHT);
   endfunction

   // Sends one whole frame; mode 0 random, 1 a counting pattern from base.
   task automatic send_frame(int mode, logic [31:0] base);
      int n;
      n = frame_pixels();
      for (int i = 0; i < n; i++)
         send_word(REQ_PIXEL, mode ? base + i : $urandom());
   endtask

   task automatic test_directed();
      set_frame(11'd2, 11'd1, 1'b0);
      send_word(REQ_PIXEL, 32'h0000_0000);
      send_word(REQ_PIXEL, 32'hFFFF_FFFF);
      send_word(REQ_COMMIT, 32'h0);
      set_frame(11'd0, 11'd0, 1'b1);
      send_word(REQ_PIXEL, 32'hA5A5_5A5A);
      send_word(REQ_PIXEL, 32'hA5A5_5A5A);
      send_word(REQ_COMMIT, 32'hFFFF_FFFF);
      send_word(REQ_PIXEL, 32'hA5A5_5A5A);
      send_word(REQ_PIXEL, 32'h1234_5678);
      // Oversized values saturate; a few pixels at the top of a huge frame.
      set_frame(11'd2047, 11'd2047, 1'b1);
      for (int i = 0; i < 6; i++) send_word(REQ_PIXEL, 32'h8000_0001 << i);
      // Size change mid-frame ends the row and frame at once.
      set_frame(11'd1, 11'd1, 1'b1);
      send_word(REQ_PIXEL, 32'h0);
      set_frame(11'd3, 11'd2, 1'b1);
      send_word(REQ_PIXEL, 32'h1);
      wait_drained();
      write_csr(CSR_DIFF, 11'd0);
      for (int i = 0; i < 5; i++) send_word(REQ_PIXEL, 32'h7);
   endtask

   task automatic test_diff_frames();
      for (int f = 0; f < 20; f++) begin
         if (f % 5 == 0)
            set_frame(11'($urandom_range(1, 9)), 11'($urandom_range(1, 6)),
                      1'($urandom_range(0, 1)));
         else if (f % 5 == 3) set_frame(cfg_width, cfg_height, ~cfg_diff);
         if ($urandom_range(0, 2) == 0) send_frame(0, 0);
         else send_frame(1, $urandom_range(0, 3));
         if ($urandom_range(0, 1)) send_word(REQ_COMMIT, $urandom());
      end
   endtask

   task automatic test_edge_tiles();
      // Crosses tile boundaries in x (a single row just past one tile), then in y.
      set_frame(11'd70, 11'd1, 1'b1);
      send_frame(1, 0);
      send_word(REQ_COMMIT, 0);
      send_frame(1, 0);
      send_word(REQ_COMMIT, 0);
      send_frame(0, 0);
      set_frame(11'd1, 11'd66, 1'b1);
      send_frame(1, 5);
      send_word(REQ_COMMIT, 0);
      send_frame(0, 0);
   endtask

   task automatic test_random_noise();
      set_frame(11'd5, 11'd4, 1'b1);
      for (int i = 0; i < 250; i++) begin
         if (i == 150) idle_on = 1'b0;
         if ($urandom_range(0, 9) == 0) send_word(REQ_COMMIT, $urandom());
         else send_word(REQ_PIXEL, $urandom_range(0, 3));
      end
   endtask

   // Result checker with random receiver stalls.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.r.kind = rsp.kind; got.r.x = rsp.rect_x; got.r.y = rsp.rect_y;
         got.r.w = rsp.rect_w; got.r.h = rsp.rect_h; got.r.dirty = rsp.any_dirty;
         got.last = rsp.last;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result word expected none actual %h", $time, got);
            errors++;
         end else begin
            exp_w = pending_rsp.pop_front();
            if (got !== exp_w) begin
               $display("%0t: result mismatch expected %h actual %h", $time, exp_w, got);
               errors++;
            end
         end
      end
   end

   initial begin
      req.valid = 1'b0; req.req_type = REQ_PIXEL; req.pixel = '0;
      csr.valid = 1'b0; csr.index = CSR_WIDTH; csr.data = '0;
      prev_half = 1'b0; col = 0; row = 0; frame_dirty = 1'b0;
      cfg_width = 11'd1024; cfg_height = 11'd1024; cfg_diff = 1'b0;
      foreach (tile_hash_mem[k]) tile_hash_mem[k] = '0;
      foreach (run_hash[k]) begin
         run_hash[k] = FNV_BASIS;
         tile_diff[k] = 1'b0;
      end
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_diff_frames();
      test_edge_tiles();
      test_random_noise();
      wait_drained();
      if (errors == 0) $display("dirty_tile_detector_tb OK");
      else $display("dirty_tile_detector_tb NOT OK");
      $finish;
   end

   initial begin
      #200ms;
      $display("dirty_tile_detector_tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
rtl/dtd_pkg.sv
rtl/dtd_if.sv
rtl/dtd_ram.sv
rtl/dtd_hasher.sv
rtl/dirty_tile_detector.sv
dv/dirty_tile_detector_tb.sv
